[rtl/ibts_pkg.sv]
// Shared constants, types and the digit-to-character function for the base conversion block.
`default_nettype none

package ibts_pkg;

   localparam int DEFAULT_WORD_BITS = 32;
   localparam int DEFAULT_MAX_CHARS = 33;

   localparam int BASE_W  = 6;
   localparam int DIGIT_W = 6;
   localparam int CHAR_W  = 7;

   localparam logic [BASE_W-1:0]  BASE_MIN   = 6'd2;
   localparam logic [BASE_W-1:0]  BASE_MAX   = 6'd36;
   localparam logic [DIGIT_W-1:0] DIGIT_SPAN = 6'd36;
   localparam logic [DIGIT_W-1:0] DEC_SPAN   = 6'd10;

   localparam logic [CHAR_W-1:0] CHAR_NONE  = 7'h00;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
   localparam logic [CHAR_W-1:0] CHAR_A     = 7'h61;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SIGN,
      ST_READ,
      ST_EMIT
   } state_type;

   // Status the serial divider hands back at the end of one division.
   typedef struct packed {
      logic               done;
      logic               nonzero;
      logic [DIGIT_W-1:0] remainder;
   } div_status_type;

   // Maps a digit value to its ASCII character from 0-9 then a-z.
   function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
      logic [DIGIT_W-1:0] r;
      r = (d >= DIGIT_SPAN) ? (d - DIGIT_SPAN) : d;
      if (r < DEC_SPAN) begin
         return CHAR_ZERO + CHAR_W'(r);
      end else begin
         return CHAR_A + CHAR_W'(r - DEC_SPAN);
      end
   endfunction

endpackage

`default_nettype wire

[rtl/ibts_divider.sv]
// Bit-serial restoring divider: one quotient bit per cycle by a small radix.
`default_nettype none

module ibts_divider
   import ibts_pkg::*;
#(
   parameter int WORD_BITS = DEFAULT_WORD_BITS
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [WORD_BITS-1:0] dividend,
   input  wire logic [BASE_W-1:0]    base,
   output logic [WORD_BITS-1:0]      quotient,
   output div_status_type            status
);

   localparam int CNT_W = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
   localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(WORD_BITS - 1);

   logic [WORD_BITS-1:0] quo_ff, quo_in;
   logic [DIGIT_W-1:0]   rem_ff, rem_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic                 nz_ff, nz_in;

   logic [DIGIT_W:0] trial;
   logic             fits;

   // The remainder stays below the base, so the trial value fits in seven bits.
   assign trial = {rem_ff, quo_ff[WORD_BITS-1]};
   assign fits  = trial >= {1'b0, base};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      nz_in   = nz_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         cnt_in = '0;
         run_in = 1'b1;
         nz_in  = 1'b0;
      end else if (run_ff) begin
         quo_in = {quo_ff[WORD_BITS-2:0], fits};
         rem_in = fits ? DIGIT_W'(trial - {1'b0, base}) : DIGIT_W'(trial);
         nz_in  = nz_ff | fits;
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == LAST_BIT) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      nz_ff  <= nz_in;
   end

   assign quotient         = quo_ff;
   assign status.done      = done_ff;
   assign status.nonzero   = nz_ff;
   assign status.remainder = rem_ff;

endmodule

`default_nettype wire

[rtl/ibts_digit_mem.sv]
// Digit store: one write port and one registered read port.
`default_nettype none

module ibts_digit_mem
   import ibts_pkg::*;
#(
   parameter int DEPTH  = DEFAULT_MAX_CHARS,
   parameter int ADDR_W = $clog2(DEFAULT_MAX_CHARS)
) (
   input  wire logic               clock,
   input  wire logic               wr_en,
   input  wire logic [ADDR_W-1:0]  wr_addr,
   input  wire logic [DIGIT_W-1:0] wr_data,
   input  wire logic               rd_en,
   input  wire logic [ADDR_W-1:0]  rd_addr,
   output logic [DIGIT_W-1:0]      rd_data
);

   logic [DIGIT_W-1:0] mem_ff [DEPTH];
   logic [DIGIT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/integer_to_base_string.sv]
// Top level: converts a signed integer to its text form in base 2 to 36.
// The block takes one request at a time: a request is accepted at a rising edge where start
// is high and busy is low. A valid base turns the magnitude of req_value into digits, least
// significant first, with a bit-serial divider, and writes each remainder to the digit store.
// The digits are then played back from the digit store, most significant first, each one
// through a read state and then an output state, after a leading '-' for a negative value.
// An invalid base (0, 1 or above 36) gives one result with rsp_empty_res and rsp_last high
// and rsp_character zero on the next cycle, and busy does not rise. Each result is shown
// for exactly one cycle with rsp_valid high; the receiver cannot stall the block and must
// take every result as it comes. The final character of a conversion carries rsp_last.
`default_nettype none

module integer_to_base_string
   import ibts_pkg::*;
#(
   parameter int WORD_BITS = DEFAULT_WORD_BITS,
   parameter int MAX_CHARS = DEFAULT_MAX_CHARS
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic signed [WORD_BITS-1:0] req_value,
   input  wire logic [BASE_W-1:0]           req_base,
   output logic                             rsp_valid,
   output logic [CHAR_W-1:0]                rsp_character,
   output logic                             rsp_empty_res,
   output logic                             rsp_last
);

   // The digit count never reaches MAX_CHARS, so one address width serves both.
   localparam int ADDR_W = $clog2(MAX_CHARS);
   localparam logic [ADDR_W-1:0] DIGIT_LIMIT = ADDR_W'(MAX_CHARS - 1);

   state_type state_ff, state_in;

   logic [ADDR_W-1:0] count_ff, count_in;
   logic              neg_ff, neg_in;
   logic [BASE_W-1:0] base_ff, base_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0] char_ff, char_in;
   logic              empty_ff, empty_in;
   logic              last_ff, last_in;

   logic                 accept;
   logic                 base_ok;
   logic [WORD_BITS-1:0] value_u;
   logic [WORD_BITS-1:0] magnitude;
   logic [ADDR_W-1:0]    count_next;

   logic                 div_start;
   logic [WORD_BITS-1:0] div_dividend;
   logic [WORD_BITS-1:0] div_quotient;
   div_status_type       div_status;

   logic               mem_wr_en;
   logic               mem_rd_en;
   logic [ADDR_W-1:0]  mem_rd_addr;
   logic [DIGIT_W-1:0] mem_rd_data;

   assign accept     = start && !busy;
   assign base_ok    = (req_base >= BASE_MIN) && (req_base <= BASE_MAX);
   assign value_u    = req_value;
   // Negating in unsigned arithmetic makes the most negative value its own exact magnitude.
   assign magnitude  = value_u[WORD_BITS-1] ? (~value_u + WORD_BITS'(1)) : value_u;
   assign count_next = count_ff + ADDR_W'(1);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      neg_in       = neg_ff;
      base_in      = base_ff;
      rsp_valid_in = 1'b0;
      char_in      = char_ff;
      empty_in     = 1'b0;
      last_in      = 1'b0;
      div_start    = 1'b0;
      div_dividend = div_quotient;
      mem_wr_en    = 1'b0;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = count_ff - ADDR_W'(1);

      unique case (state_ff)
         ST_IDLE: begin
            div_dividend = magnitude;
            if (accept) begin
               if (!base_ok) begin
                  // Rejected base: one empty result, conversion state untouched.
                  rsp_valid_in = 1'b1;
                  char_in      = CHAR_NONE;
                  empty_in     = 1'b1;
                  last_in      = 1'b1;
               end else begin
                  neg_in    = value_u[WORD_BITS-1];
                  base_in   = req_base;
                  count_in  = '0;
                  div_start = 1'b1;
                  state_in  = ST_DIVIDE;
               end
            end
         end
         ST_DIVIDE: begin
            if (div_status.done) begin
               // Store this digit, then either divide the quotient again or play back.
               mem_wr_en = 1'b1;
               count_in  = count_next;
               if (div_status.nonzero && (count_next < DIGIT_LIMIT)) begin
                  div_start = 1'b1;
               end else if (neg_ff) begin
                  state_in = ST_SIGN;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_SIGN: begin
            rsp_valid_in = 1'b1;
            char_in      = CHAR_MINUS;
            state_in     = ST_READ;
         end
         ST_READ: begin
            mem_rd_en = 1'b1;
            count_in  = count_ff - ADDR_W'(1);
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            rsp_valid_in = 1'b1;
            char_in      = digit_char(mem_rd_data);
            if (count_ff == '0) begin
               last_in  = 1'b1;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff   <= neg_in;
      base_ff  <= base_in;
      char_ff  <= char_in;
      empty_ff <= empty_in;
      last_ff  <= last_in;
   end

   ibts_divider #(
      .WORD_BITS (WORD_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .base     (base_ff),
      .quotient (div_quotient),
      .status   (div_status)
   );

   ibts_digit_mem #(
      .DEPTH  (MAX_CHARS),
      .ADDR_W (ADDR_W)
   ) u_digit_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (count_ff),
      .wr_data (div_status.remainder),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = char_ff;
   assign rsp_empty_res = empty_ff;
   assign rsp_last      = last_ff;

endmodule

`default_nettype wire

[rtl/ibts_checker.sv]
// Port-level checker for the base conversion block, bound to its top level.
`default_nettype none

module ibts_checker
   import ibts_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              start,
   input wire logic              busy,
   input wire logic [BASE_W-1:0] req_base,
   input wire logic              rsp_valid,
   input wire logic [CHAR_W-1:0] rsp_character,
   input wire logic              rsp_empty_res,
   input wire logic              rsp_last
);

   // An empty result is a single, final result with no character.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_res |-> rsp_last && (rsp_character == CHAR_NONE))
      else $error("empty result not final or carries a character");

   // While a conversion still has characters to give, the block stays busy.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> busy)
      else $error("block idle in the middle of a conversion");

   // A request with a valid base starts a conversion.
   assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_base >= BASE_MIN) && (req_base <= BASE_MAX) |=> busy)
      else $error("valid request did not start a conversion");

   // A request with an invalid base is answered on the next cycle by an empty result.
   assert property (@(posedge clock) disable iff (reset)
      start && !busy && ((req_base < BASE_MIN) || (req_base > BASE_MAX))
      |=> rsp_valid && rsp_empty_res && !busy)
      else $error("invalid base not answered by an empty result");

   // A minus sign is never the final character.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_character == CHAR_MINUS) |-> !rsp_last && !rsp_empty_res)
      else $error("minus sign ends a conversion");

endmodule

bind integer_to_base_string ibts_checker u_ibts_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .req_base      (req_base),
   .rsp_valid     (rsp_valid),
   .rsp_character (rsp_character),
   .rsp_empty_res (rsp_empty_res),
   .rsp_last      (rsp_last)
);

`default_nettype wire

[dv/tb.sv]
// Self-checking testbench for the integer to base-N text conversion block.
module tb;
   import ibts_pkg::*;

   localparam int WORD_BITS       = DEFAULT_WORD_BITS;
   localparam int HALF_PERIOD     = 6;
   localparam int RESET_CYCLES    = 6;
   localparam int RANDOM_REQUESTS = 90;
   // The slowest request is a 32-digit base-2 conversion; this settle time is still far more
   // than the block needs once the last character is out.
   localparam int SETTLE_CYCLES   = 40;
   // Time limit: several times the slowest legal run of all requests.
   localparam int RUN_LIMIT       = 2 * HALF_PERIOD * 700000;
   localparam int REPORT_LIMIT    = 10;

   // One character of the text output, laid out like the result ports.
   typedef struct packed {
      logic [CHAR_W-1:0] character;
      logic              empty_res;
      logic              last;
   } text_char_type;

   // Keeps the characters still owed by the block and checks each one as it appears.
   class conversion_ledger;
      text_char_type pending_chars[$];
      int            mismatch_count;
      int            chars_checked;
      int            requests_noted;
      int            invalid_requests;
      int            negative_requests;

      function new();
         mismatch_count    = 0;
         chars_checked     = 0;
         requests_noted    = 0;
         invalid_requests  = 0;
         negative_requests = 0;
      endfunction

      function int pending();
         return pending_chars.size();
      endfunction

      // Spells out the accepted request in its base and queues the characters it yields.
      function void note_request(logic signed [WORD_BITS-1:0] value,
                                 logic [BASE_W-1:0] base);
         string                alphabet;
         text_char_type        ch;
         logic [WORD_BITS-1:0] mag;
         logic [DIGIT_W-1:0]   digits[$];
         alphabet = "0123456789abcdefghijklmnopqrstuvwxyz";
         requests_noted++;
         if (base < BASE_MIN || base > BASE_MAX) begin
            // An unsupported base yields a single empty marker and nothing else.
            ch.character = CHAR_NONE;
            ch.empty_res = 1'b1;
            ch.last      = 1'b1;
            pending_chars.push_back(ch);
            invalid_requests++;
            return;
         end
         // The magnitude is taken as an unsigned word, so the most negative value
         // turns into 2^(WORD_BITS-1) rather than overflowing.
         mag = value[WORD_BITS-1] ? (~value + 1'b1) : value;
         do begin
            digits.push_front(DIGIT_W'(mag % base));
            mag = mag / base;
         end while (mag != 0);
         if (value[WORD_BITS-1]) begin
            ch.character = CHAR_MINUS;
            ch.empty_res = 1'b0;
            ch.last      = 1'b0;
            pending_chars.push_back(ch);
            negative_requests++;
         end
         foreach (digits[i]) begin
            ch.character = CHAR_W'(alphabet.getc(digits[i]));
            ch.empty_res = 1'b0;
            ch.last      = (i == digits.size() - 1);
            pending_chars.push_back(ch);
         end
      endfunction

      // Compares one character from the block with the oldest one still owed.
      function void check_char(logic [CHAR_W-1:0] character, logic empty_res, logic last);
         text_char_type want;
         text_char_type got;
         got.character = character;
         got.empty_res = empty_res;
         got.last      = last;
         if (pending_chars.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("Unexpected character at %0t: char=%h empty=%b last=%b",
                        $realtime, character, empty_res, last);
            return;
         end
         want = pending_chars.pop_front();
         chars_checked++;
         if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display({"Mismatch at %0t: expected char=%h empty=%b last=%b, ",
                         "got char=%h empty=%b last=%b"},
                        $realtime, want.character, want.empty_res, want.last,
                        got.character, got.empty_res, got.last);
         end
      endfunction
   endclass

   logic                        clock;
   logic                        reset;
   logic                        start;
   logic                        busy;
   logic signed [WORD_BITS-1:0] req_value;
   logic [BASE_W-1:0]           req_base;
   logic                        rsp_valid;
   logic [CHAR_W-1:0]           rsp_character;
   logic                        rsp_empty_res;
   logic                        rsp_last;

   conversion_ledger ledger;
   bit               burst_mode;

   integer_to_base_string uut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_value     (req_value),
      .req_base      (req_base),
      .rsp_valid     (rsp_valid),
      .rsp_character (rsp_character),
      .rsp_empty_res (rsp_empty_res),
      .rsp_last      (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #(HALF_PERIOD) clock = ~clock;
   end

   // Hard stop in case the block hangs or never finishes a conversion.
   initial begin
      #(RUN_LIMIT);
      $display("RESULT: ERROR");
      $finish;
   end

   // The receiver cannot push back, so every strobed character is checked at the edge
   // that ends its cycle. Reading at the edge sees the values from before the edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1)
         ledger.check_char(rsp_character, rsp_empty_res, rsp_last);
   end

   // Holds a request on the ports until an edge sees start high and busy low. The task
   // returns in the time step of that edge and leaves start high, so a following request
   // can go out back to back without start dropping in between.
   task automatic send_request(input logic signed [WORD_BITS-1:0] value,
                               input logic [BASE_W-1:0] base);
      req_value <= value;
      req_base  <= base;
      start     <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      ledger.note_request(value, base);
   endtask

   // Drops start over the idle gap and puts junk on the request fields, which the block
   // must ignore while start is low.
   task automatic idle_cycles(input int n);
      if (n > 0) begin
         start     <= 1'b0;
         req_value <= $urandom;
         req_base  <= $urandom_range(0, 63);
         repeat (n) @(posedge clock);
      end
   endtask

   // Mostly no gap or a short one, now and then a long pause. In burst mode the
   // sender never idles, so requests are offered the moment busy falls.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (burst_mode || roll < 45)
         return 0;
      else if (roll < 85)
         return $urandom_range(1, 3);
      else
         return $urandom_range(10, 60);
   endfunction

   task automatic request_then_idle(input logic signed [WORD_BITS-1:0] value,
                                    input logic [BASE_W-1:0] base);
      send_request(value, base);
      idle_cycles(pick_gap());
   endtask

   // Stops sending and waits for every owed character to come out.
   task automatic drain_results();
      start <= 1'b0;
      while (ledger.pending() != 0) @(posedge clock);
   endtask

   // Mix of full-width words, which exercise every bit, small and medium magnitudes,
   // which keep most conversions short, and the word boundaries.
   function automatic logic signed [WORD_BITS-1:0] pick_value();
      logic signed [WORD_BITS-1:0] v;
      case ($urandom_range(0, 9))
         0, 1, 2: v = $urandom;
         3, 4, 5, 6: v = $urandom_range(0, 5000);
         7: begin
            case ($urandom_range(0, 4))
               0: v = 0;
               1: v = 1;
               2: v = -1;
               3: v = {1'b0, {(WORD_BITS-1){1'b1}}};
               default: v = {1'b1, {(WORD_BITS-1){1'b0}}};
            endcase
         end
         default: v = $urandom_range(0, 1 << 20);
      endcase
      // Any positive pick gets a random sign as well.
      if ($urandom_range(0, 1) == 1 && v > 0)
         v = -v;
      return v;
   endfunction

   // Mostly supported bases, with the common ones favored and some unsupported ones.
   function automatic logic [BASE_W-1:0] pick_base();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 12) begin
         case ($urandom_range(0, 2))
            0: return 6'd0;
            1: return 6'd1;
            default: return BASE_W'($urandom_range(37, 63));
         endcase
      end else if (roll < 22) begin
         case ($urandom_range(0, 3))
            0: return 6'd2;
            1: return 6'd10;
            2: return 6'd16;
            default: return 6'd36;
         endcase
      end
      return BASE_W'($urandom_range(2, 36));
   endfunction

   initial begin
      ledger     = new();
      burst_mode = 1'b0;
      reset     <= 1'b1;
      start     <= 1'b0;
      req_value <= '0;
      req_base  <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed requests: zero in the smallest and a common base, the most negative word in bases
      // 2, 10, 16 and 36 (it must convert exactly) and the most positive in bases 2 and 36, the
      // top digit of base 36, a few ordinary values, and each kind of unsupported base.
      request_then_idle(0, 10);
      request_then_idle(0, 2);
      request_then_idle(1, 2);
      request_then_idle(-1, 2);
      request_then_idle(32'sh7fffffff, 2);
      request_then_idle(32'sh80000000, 2);
      request_then_idle(32'sh80000000, 10);
      request_then_idle(32'sh80000000, 16);
      request_then_idle(32'sh80000000, 36);
      request_then_idle(32'sh7fffffff, 36);
      request_then_idle(35, 36);
      request_then_idle(-35, 36);
      request_then_idle(1295, 36);
      request_then_idle(80, 3);
      request_then_idle(123456789, 10);
      request_then_idle(-255, 16);
      request_then_idle(32'shdeadbeef, 16);
      // Unsupported bases, including back to back with a valid request, since they
      // answer on the next cycle without raising busy.
      send_request(12345, 0);
      send_request(-7, 1);
      send_request(42, 37);
      send_request(-1, 63);
      request_then_idle(9, 10);

      // Let the block go fully quiet once before the random part.
      drain_results();

      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         // The first five of every twenty requests are sent without any gap.
         burst_mode = (i % 20) < 5;
         request_then_idle(pick_value(), pick_base());
         if (i == RANDOM_REQUESTS / 2)
            drain_results();
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Converted %0d requests (%0d with an unsupported base, %0d negative),",
               ledger.requests_noted, ledger.invalid_requests, ledger.negative_requests);
      $display("checked %0d characters, %0d mismatches, %0d characters still owed.",
               ledger.chars_checked, ledger.mismatch_count, ledger.pending());
      if (ledger.mismatch_count == 0 && ledger.pending() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
